// ----- hw/rtl/path_gradient_smoother_assert.svh -----
// Assertion macros used by the path smoother top level.
`ifndef PATH_GRADIENT_SMOOTHER_ASSERT_SVH
`define PATH_GRADIENT_SMOOTHER_ASSERT_SVH

`ifndef SYNTH

`define PGS_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

`define PGS_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`define PGS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define PGS_ASSERT(name, clk, rst, prop)
`define PGS_ASSERT_IMPL(name, clk, rst, ante, cons)
`define PGS_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/pgs_pkg.sv -----
// Shared widths, register codes and control types of the path smoother.
package pgs_pkg;

  localparam int CoordW  = 32;
  localparam int AxisN   = 3;
  localparam int PointW  = CoordW * AxisN;
  localparam int WeightW = 16;
  localparam int TolW    = 32;
  localparam int SumW    = 40;
  localparam int SqW     = 64;
  localparam int RootW   = 32;

  localparam logic [WeightW-1:0] DataWeightRst   = 16'd32768;
  localparam logic [WeightW-1:0] SmoothWeightRst = 16'd6554;
  localparam logic [TolW-1:0]    StopTolRst      = 32'd66;

  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 32;
  localparam logic [CfgAddrW-1:0] CfgDataWeight   = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgSmoothWeight = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgStopTol      = 2'd2;

  typedef struct packed {
    logic store;
    logic cap_prev;
    logic cap_cur;
    logic cap_next;
    logic mul_data;
    logic calc_t;
    logic mul_smooth;
    logic calc_nw;
    logic wb;
    logic cap_orig;
    logic square;
    logic sum_sq;
    logic acc;
    logic clr_sum;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic root_done;
    logic converged;
  } dp_status_t;

endpackage

// ----- hw/rtl/pgs_ram.sv -----
// Generic simple dual-port RAM with registered read.
module pgs_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/pgs_isqrt.sv -----
// Iterative integer square root, one result bit per cycle.
module pgs_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pgs_pkg::SqW-1:0]   value,
  output logic [pgs_pkg::RootW-1:0] root,
  output logic                      done
);

  logic [pgs_pkg::SqW-1:0] rem;
  logic [pgs_pkg::SqW-1:0] res;
  logic [pgs_pkg::SqW-1:0] bitm;
  logic [pgs_pkg::SqW-1:0] trial;
  logic                    busy;

  assign trial = res + bitm;
  assign root  = res[pgs_pkg::RootW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && bitm[0]) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= value;
      res  <= '0;
      bitm <= pgs_pkg::SqW'(1) << (pgs_pkg::SqW - 2);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule

// ----- hw/rtl/pgs_dp.sv -----
// Datapath: point stores, per-axis update arithmetic, change sum and output register.
module pgs_dp #(
  parameter int MAX_POINTS = 64,
  parameter int IdxW = $clog2(MAX_POINTS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [pgs_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [pgs_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic [pgs_pkg::PointW-1:0]   in_data,
  input  pgs_pkg::dp_cmd_t             cmd,
  input  logic [IdxW-1:0]              waddr,
  input  logic [IdxW-1:0]              raddr,
  output pgs_pkg::dp_status_t          status,
  output logic [pgs_pkg::PointW-1:0]   out_data
);

  logic [pgs_pkg::WeightW-1:0] data_weight;
  logic [pgs_pkg::WeightW-1:0] smooth_weight;
  logic [pgs_pkg::TolW-1:0]    stop_tol;
  logic signed [16:0]          dw_s;
  logic signed [16:0]          sw_s;

  logic [pgs_pkg::PointW-1:0]  work_rd;
  logic [pgs_pkg::PointW-1:0]  orig_rd;
  logic [pgs_pkg::PointW-1:0]  work_wd;
  logic                        work_we;

  logic [pgs_pkg::AxisN-1:0][pgs_pkg::CoordW-1:0] nw_all;
  logic [pgs_pkg::AxisN-1:0][61:0]                sq_all;
  logic [pgs_pkg::SqW-1:0]                        sq_total;
  logic [pgs_pkg::RootW-1:0]                      root;
  logic                                           root_done;
  logic [pgs_pkg::SumW-1:0]                       change_sum;
  logic [pgs_pkg::SumW:0]                         sum_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_weight   <= pgs_pkg::DataWeightRst;
      smooth_weight <= pgs_pkg::SmoothWeightRst;
      stop_tol      <= pgs_pkg::StopTolRst;
    end else if (cfg_we) begin
      case (cfg_addr)
        pgs_pkg::CfgDataWeight:   data_weight   <= cfg_wdata[pgs_pkg::WeightW-1:0];
        pgs_pkg::CfgSmoothWeight: smooth_weight <= cfg_wdata[pgs_pkg::WeightW-1:0];
        pgs_pkg::CfgStopTol:      stop_tol      <= cfg_wdata[pgs_pkg::TolW-1:0];
        default: ;
      endcase
    end
  end

  assign dw_s = $signed({1'b0, data_weight});
  assign sw_s = $signed({1'b0, smooth_weight});

  assign work_we = cmd.store | cmd.wb;
  assign work_wd = cmd.store ? in_data : nw_all;

  pgs_ram #(.Width(pgs_pkg::PointW), .Depth(MAX_POINTS)) u_orig_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (waddr),
    .wdata (in_data),
    .raddr (raddr),
    .rdata (orig_rd)
  );

  pgs_ram #(.Width(pgs_pkg::PointW), .Depth(MAX_POINTS)) u_work_ram (
    .clk   (clk),
    .we    (work_we),
    .waddr (waddr),
    .wdata (work_wd),
    .raddr (raddr),
    .rdata (work_rd)
  );

  for (genvar a = 0; a < pgs_pkg::AxisN; a++) begin : g_axis
    localparam int Lo = a * pgs_pkg::CoordW;

    logic signed [31:0] prev;
    logic signed [31:0] cur;
    logic signed [31:0] nxt;
    logic signed [31:0] orig;
    logic signed [31:0] nw;
    logic signed [49:0] prod_d;
    logic signed [34:0] t;
    logic signed [52:0] prod_s;
    logic [30:0]        dmag;
    logic [61:0]        sq;

    logic signed [32:0] diff;
    logic signed [49:0] pd_next;
    logic signed [49:0] pd_rnd;
    logic signed [33:0] rnd_d;
    logic signed [34:0] t_next;
    logic signed [35:0] s;
    logic signed [52:0] ps_next;
    logic signed [52:0] ps_rnd;
    logic signed [36:0] rnd_s;
    logic signed [37:0] v;
    logic signed [31:0] nw_next;
    logic signed [32:0] d;
    logic [32:0]        dabs;
    logic [30:0]        dmag_next;

    // Adding half an LSB and shifting right rounds half toward +infinity.
    always_comb begin
      diff    = $signed({orig[31], orig}) - $signed({cur[31], cur});
      pd_next = dw_s * diff;
      pd_rnd  = prod_d + 50'sd32768;
      rnd_d   = pd_rnd[49:16];
      t_next  = 35'(cur) + 35'(rnd_d);
      s       = 36'(prev) + 36'(nxt) - (36'(t) <<< 1);
      ps_next = sw_s * s;
      ps_rnd  = prod_s + 53'sd32768;
      rnd_s   = ps_rnd[52:16];
      v       = 38'(t) + 38'(rnd_s);
      if (v > 38'sd2147483647) begin
        nw_next = 32'sh7FFFFFFF;
      end else if (v < -38'sd2147483648) begin
        nw_next = 32'sh80000000;
      end else begin
        nw_next = v[31:0];
      end
      d         = 33'(cur) - 33'(nw);
      dabs      = d[32] ? 33'(-d) : 33'(d);
      dmag_next = (dabs[32:31] != 2'b00) ? 31'h7FFFFFFF : dabs[30:0];
    end

    always_ff @(posedge clk) begin
      if (cmd.cap_prev) begin
        prev <= work_rd[Lo +: 32];
      end else if (cmd.wb) begin
        prev <= nw;
      end
      if (cmd.cap_cur) begin
        cur <= work_rd[Lo +: 32];
      end else if (cmd.wb) begin
        cur <= nxt;
      end
      if (cmd.cap_cur || cmd.cap_orig) begin
        orig <= orig_rd[Lo +: 32];
      end
      if (cmd.cap_next) begin
        nxt <= work_rd[Lo +: 32];
      end
      if (cmd.mul_data) begin
        prod_d <= pd_next;
      end
      if (cmd.calc_t) begin
        t <= t_next;
      end
      if (cmd.mul_smooth) begin
        prod_s <= ps_next;
      end
      if (cmd.calc_nw) begin
        nw <= nw_next;
      end
      if (cmd.wb) begin
        dmag <= dmag_next;
      end
      if (cmd.square) begin
        sq <= dmag * dmag;
      end
    end

    assign nw_all[a] = nw;
    assign sq_all[a] = sq;
  end

  assign sq_total = pgs_pkg::SqW'(sq_all[0]) + pgs_pkg::SqW'(sq_all[1])
                  + pgs_pkg::SqW'(sq_all[2]);

  pgs_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sum_sq),
    .value (sq_total),
    .root  (root),
    .done  (root_done)
  );

  assign sum_wide = {1'b0, change_sum} + (pgs_pkg::SumW + 1)'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      change_sum <= '0;
    end else if (cmd.clr_sum) begin
      change_sum <= '0;
    end else if (cmd.acc) begin
      change_sum <= sum_wide[pgs_pkg::SumW] ? '1 : sum_wide[pgs_pkg::SumW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= work_rd;
    end
  end

  assign status.root_done = root_done;
  assign status.converged = change_sum < pgs_pkg::SumW'(stop_tol);

endmodule

// ----- hw/rtl/pgs_ctrl.sv -----
// Controller: load, sweep and emit sequencing of the path smoother.
module pgs_ctrl #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_SWEEPS = 4096,
  parameter int IdxW = $clog2(MAX_POINTS),
  parameter int CntW = $clog2(MAX_POINTS + 1),
  parameter int SwW  = $clog2(MAX_SWEEPS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_last,
  output logic                out_flag,
  output pgs_pkg::dp_cmd_t    cmd,
  input  pgs_pkg::dp_status_t status,
  output logic [IdxW-1:0]     waddr,
  output logic [IdxW-1:0]     raddr
);

  localparam logic [4:0] ST_LOAD    = 5'd0;
  localparam logic [4:0] ST_SW_RD0  = 5'd1;
  localparam logic [4:0] ST_SW_RD1  = 5'd2;
  localparam logic [4:0] ST_SW_RD2  = 5'd3;
  localparam logic [4:0] ST_PT_RDN  = 5'd4;
  localparam logic [4:0] ST_PT_MUL  = 5'd5;
  localparam logic [4:0] ST_PT_T    = 5'd6;
  localparam logic [4:0] ST_PT_S    = 5'd7;
  localparam logic [4:0] ST_PT_NW   = 5'd8;
  localparam logic [4:0] ST_PT_WB   = 5'd9;
  localparam logic [4:0] ST_PT_SQ   = 5'd10;
  localparam logic [4:0] ST_PT_SUM  = 5'd11;
  localparam logic [4:0] ST_PT_ROOT = 5'd12;
  localparam logic [4:0] ST_SW_END  = 5'd13;
  localparam logic [4:0] ST_EM_RD   = 5'd14;
  localparam logic [4:0] ST_EM_LD   = 5'd15;
  localparam logic [4:0] ST_EM_OUT  = 5'd16;

  logic [4:0]      state, state_next;
  logic [IdxW-1:0] idx, idx_next;
  logic [CntW-1:0] npts, npts_next;
  logic [SwW-1:0]  sweeps, sweeps_next;
  logic            nc, nc_next;

  logic [IdxW-1:0] idx_inc;
  logic [CntW-1:0] cnt_inc;
  logic [SwW-1:0]  sweeps_inc;

  assign idx_inc    = idx + IdxW'(1);
  assign cnt_inc    = CntW'(idx) + CntW'(1);
  assign sweeps_inc = sweeps + SwW'(1);
  assign out_last   = (cnt_inc == npts);
  assign out_flag   = nc;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    npts_next   = npts;
    sweeps_next = sweeps;
    nc_next     = nc;
    cmd         = '0;
    waddr       = idx;
    raddr       = idx;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store = 1'b1;
          // A full store closes the path even without the last flag.
          if (in_last || idx == IdxW'(MAX_POINTS - 1)) begin
            npts_next   = cnt_inc;
            idx_next    = '0;
            nc_next     = 1'b0;
            sweeps_next = '0;
            state_next  = (cnt_inc >= CntW'(3)) ? ST_SW_RD0 : ST_EM_RD;
          end else begin
            idx_next = idx_inc;
          end
        end
      end
      ST_SW_RD0: begin
        raddr         = '0;
        cmd.clr_sum   = 1'b1;
        state_next    = ST_SW_RD1;
      end
      ST_SW_RD1: begin
        cmd.cap_prev = 1'b1;
        raddr        = IdxW'(1);
        state_next   = ST_SW_RD2;
      end
      ST_SW_RD2: begin
        cmd.cap_cur = 1'b1;
        idx_next    = IdxW'(1);
        state_next  = ST_PT_RDN;
      end
      ST_PT_RDN: begin
        raddr      = idx_inc;
        state_next = ST_PT_MUL;
      end
      ST_PT_MUL: begin
        cmd.cap_next = 1'b1;
        cmd.mul_data = 1'b1;
        state_next   = ST_PT_T;
      end
      ST_PT_T: begin
        cmd.calc_t = 1'b1;
        state_next = ST_PT_S;
      end
      ST_PT_S: begin
        cmd.mul_smooth = 1'b1;
        state_next     = ST_PT_NW;
      end
      ST_PT_NW: begin
        cmd.calc_nw = 1'b1;
        state_next  = ST_PT_WB;
      end
      ST_PT_WB: begin
        cmd.wb     = 1'b1;
        raddr      = idx_inc;
        state_next = ST_PT_SQ;
      end
      ST_PT_SQ: begin
        cmd.cap_orig = 1'b1;
        cmd.square   = 1'b1;
        state_next   = ST_PT_SUM;
      end
      ST_PT_SUM: begin
        cmd.sum_sq = 1'b1;
        state_next = ST_PT_ROOT;
      end
      ST_PT_ROOT: begin
        if (status.root_done) begin
          cmd.acc = 1'b1;
          if (cnt_inc + CntW'(1) >= npts) begin
            state_next = ST_SW_END;
          end else begin
            idx_next   = idx_inc;
            state_next = ST_PT_RDN;
          end
        end
      end
      ST_SW_END: begin
        sweeps_next = sweeps_inc;
        if (status.converged) begin
          idx_next   = '0;
          state_next = ST_EM_RD;
        end else if (sweeps_inc >= SwW'(MAX_SWEEPS)) begin
          nc_next    = 1'b1;
          idx_next   = '0;
          state_next = ST_EM_RD;
        end else begin
          state_next = ST_SW_RD0;
        end
      end
      ST_EM_RD: begin
        state_next = ST_EM_LD;
      end
      ST_EM_LD: begin
        cmd.out_load = 1'b1;
        state_next   = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (out_last) begin
            idx_next   = '0;
            state_next = ST_LOAD;
          end else begin
            idx_next   = idx_inc;
            state_next = ST_EM_RD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      idx    <= '0;
      npts   <= '0;
      sweeps <= '0;
      nc     <= 1'b0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      npts   <= npts_next;
      sweeps <= sweeps_next;
      nc     <= nc_next;
    end
  end

endmodule

// ----- hw/rtl/path_gradient_smoother.sv -----
// Top level of the 3-D waypoint path smoother.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+---------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready    | tdata {pos_z,pos_y,pos_x}, tlast final
//  m_axis    | out | m_axis_tvalid/tready    | tdata {out_z,out_y,out_x}, tlast end,
//            |     |                         | tuser not_converged
//  cfg       | in  | cfg_we                  | cfg_addr register, cfg_wdata value
//
// Loading accepts one waypoint per cycle while tvalid is high. Each sweep updates the
// interior points in turn; the iterative square root unit (32 steps per point) dominates it.
// Emitting reads, loads and presents each point; a stalled sink holds the beat.
// Reset is synchronous and clears control state; the point stores need no clearing.
// No waypoint is taken while a path is being smoothed or emitted.
`include "path_gradient_smoother_assert.svh"

module path_gradient_smoother #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_SWEEPS = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [pgs_pkg::PointW-1:0]   s_axis_tdata,  // pos_x, pos_y, pos_z
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [pgs_pkg::PointW-1:0]   m_axis_tdata,  // out_x, out_y, out_z
  output logic                         m_axis_tlast,
  output logic                         m_axis_tuser,  // not_converged
  input  logic                         cfg_we,
  input  logic [pgs_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [pgs_pkg::CfgDataW-1:0] cfg_wdata
);

  localparam int IdxW = $clog2(MAX_POINTS);

  pgs_pkg::dp_cmd_t    cmd;
  pgs_pkg::dp_status_t status;
  logic [IdxW-1:0]     waddr;
  logic [IdxW-1:0]     raddr;

  pgs_ctrl #(.MAX_POINTS(MAX_POINTS), .MAX_SWEEPS(MAX_SWEEPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_last  (m_axis_tlast),
    .out_flag  (m_axis_tuser),
    .cmd       (cmd),
    .status    (status),
    .waddr     (waddr),
    .raddr     (raddr)
  );

  pgs_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .waddr     (waddr),
    .raddr     (raddr),
    .status    (status),
    .out_data  (m_axis_tdata)
  );

  `PGS_ASSERT(a_load_emit_apart, clk, rst, !(s_axis_tready && m_axis_tvalid))
  `PGS_ASSERT_NEXT(a_ready_after_run, clk, rst, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)
  `PGS_ASSERT_NEXT(a_busy_after_final, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the 3-D waypoint path smoother, with its own point predictor.
module tb_top;

  localparam int NumPts     = 64;
  localparam int SweepCap   = 4096;
  localparam int RandItems  = 60;
  localparam int CycleLimit = 40000000;
  localparam logic [pgs_pkg::CfgAddrW-1:0] CfgUnused = 2'd3;
  localparam longint unsigned SumMax = 64'hFF_FFFF_FFFF;

  typedef struct {
    int x;
    int y;
    int z;
    bit eor;
    bit nc;
  } smoothed_pt_t;

  typedef struct {
    int x;
    int y;
    int z;
    bit last;
    bit typed;
  } waypoint_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [pgs_pkg::PointW-1:0] s_axis_tdata = '0;  // pos_x, pos_y, pos_z
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [pgs_pkg::PointW-1:0] m_axis_tdata;       // out_x, out_y, out_z
  logic m_axis_tlast;
  logic m_axis_tuser;                             // not_converged
  logic cfg_we = 1'b0;
  logic [pgs_pkg::CfgAddrW-1:0] cfg_addr = '0;
  logic [pgs_pkg::CfgDataW-1:0] cfg_wdata = '0;

  path_gradient_smoother DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state.
  int orig_pts[3*NumPts];
  int work_pts[3*NumPts];
  int unsigned pts_loaded = 0;
  longint data_w = pgs_pkg::DataWeightRst;
  longint smooth_w = pgs_pkg::SmoothWeightRst;
  longint unsigned stop_tol = pgs_pkg::StopTolRst;

  smoothed_pt_t smoothed_q[$];
  int mismatches = 0;
  int beats_seen = 0;
  int paths_done = 0;
  int capped_runs = 0;
  int cycles = 0;
  bit send_eager = 1'b0;
  bit typed_pending = 1'b0;
  bit stim_done = 1'b0;

  function automatic longint round_q16(longint v);
    if (v >= 0) return (v + 32768) / 65536;
    return -((-v + 32767) / 65536);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // One Gauss-Seidel pass over the interior points; returns the summed move length.
  function automatic longint unsigned smooth_pass(int unsigned n);
    longint unsigned total = 0;
    longint unsigned sq, m;
    longint w, o, t, s, nw, d;
    int k;
    for (int i = 1; i + 1 < n; i++) begin
      sq = 0;
      for (int a = 0; a < 3; a++) begin
        k = i * 3 + a;
        w = work_pts[k];
        o = orig_pts[k];
        t = w + round_q16(data_w * (o - w));
        s = longint'(work_pts[k-3]) + longint'(work_pts[k+3]) - 2 * t;
        nw = clamp32(t + round_q16(smooth_w * s));
        work_pts[k] = int'(nw);
        d = w - nw;
        if (d < 0) d = -d;
        if (d > 64'sh7FFFFFFF) d = 64'sh7FFFFFFF;
        m = d;
        sq += m * m;
      end
      total += int_sqrt(sq);
      if (total > SumMax) total = SumMax;
    end
    return total;
  endfunction

  task automatic predict_waypoint(input int x, input int y, input int z, input bit last);
    int unsigned k = pts_loaded;
    int unsigned n, sweeps;
    bit nc = 1'b0;
    smoothed_pt_t r;
    if (k >= NumPts) k = 0;
    orig_pts[k*3] = x;   work_pts[k*3] = x;
    orig_pts[k*3+1] = y; work_pts[k*3+1] = y;
    orig_pts[k*3+2] = z; work_pts[k*3+2] = z;
    pts_loaded = k + 1;
    if (!last && pts_loaded < NumPts) return;
    n = pts_loaded;
    if (n >= 3) begin
      sweeps = 0;
      forever begin
        sweeps++;
        if (smooth_pass(n) < stop_tol) break;
        if (sweeps >= SweepCap) begin
          nc = 1'b1;
          break;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r.x = work_pts[i*3];
      r.y = work_pts[i*3+1];
      r.z = work_pts[i*3+2];
      r.eor = (i + 1 == n);
      r.nc = nc;
      smoothed_q = {smoothed_q, r};
    end
    capped_runs += nc;
    paths_done++;
    pts_loaded = 0;
  endtask

  // Input beats feed the predictor; a single-point row carries its own expected result.
  always @(posedge clk) begin
    smoothed_pt_t r;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predict_waypoint(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[95:64],
                       s_axis_tlast);
      if (typed_pending) begin
        r.x = s_axis_tdata[31:0];
        r.y = s_axis_tdata[63:32];
        r.z = s_axis_tdata[95:64];
        r.eor = 1'b1;
        r.nc = 1'b0;
        smoothed_q[$] = r;
      end
    end
  end

  always @(posedge clk) begin
    smoothed_pt_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      beats_seen++;
      if (smoothed_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output beat x=%h y=%h z=%h", $time,
                 m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64]);
      end else begin
        e = smoothed_q.pop_front();
        if (m_axis_tdata[31:0] !== e.x) begin
          mismatches++;
          $display("%0t: out_x expected %h actual %h", $time, e.x, m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[63:32] !== e.y) begin
          mismatches++;
          $display("%0t: out_y expected %h actual %h", $time, e.y, m_axis_tdata[63:32]);
        end
        if (m_axis_tdata[95:64] !== e.z) begin
          mismatches++;
          $display("%0t: out_z expected %h actual %h", $time, e.z, m_axis_tdata[95:64]);
        end
        if (m_axis_tlast !== e.eor) begin
          mismatches++;
          $display("%0t: end_of_run expected %b actual %b", $time, e.eor, m_axis_tlast);
        end
        if (m_axis_tuser !== e.nc) begin
          mismatches++;
          $display("%0t: not_converged expected %b actual %b", $time, e.nc, m_axis_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Sink side: random stalls, runs of none, and one long hold-off that backs up the block.
  initial begin
    int gap;
    bit held = 1'b0;
    @(negedge rst);
    forever begin
      gap = (beats_seen % 64 < 24) ? 0 : $urandom_range(0, 6);
      if (!held && beats_seen >= 120) begin
        held = 1'b1;
        gap = 400;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic send_waypoint(input int x, input int y, input int z, input bit last,
                               input bit typed);
    int gap = send_eager ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    s_axis_tlast <= last;
    typed_pending <= typed;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [pgs_pkg::CfgAddrW-1:0] idx,
                           input logic [pgs_pkg::CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      pgs_pkg::CfgDataWeight: data_w = val[15:0];
      pgs_pkg::CfgSmoothWeight: smooth_w = val[15:0];
      pgs_pkg::CfgStopTol: stop_tol = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Waits for the block to drain, then applies a full register setting.
  task automatic reconfigure(input int dw, input int sw, input int unsigned tol);
    s_axis_tvalid <= 1'b0;
    typed_pending <= 1'b0;
    // Waiting for an edge lets the predictor take the final beat before the queue is polled.
    @(posedge clk);
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    write_reg(pgs_pkg::CfgDataWeight, dw);
    write_reg(pgs_pkg::CfgSmoothWeight, sw);
    write_reg(pgs_pkg::CfgStopTol, tol);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  waypoint_row_t directed[] = '{
    '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b1},
    '{32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b1},
    '{32'h00000000, 32'hFFFFFFFF, 32'h80000000, 1'b1, 1'b1},
    '{32'h12345678, 32'hEDCBA987, 32'h00010000, 1'b1, 1'b1},
    '{32'h80000000, 32'h7FFFFFFF, 32'h00000000, 1'b0, 1'b0},
    '{32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1'b1, 1'b0},
    '{32'h00000000, 32'h00000000, 32'h00000000, 1'b0, 1'b0},
    '{32'h00000000, 32'h00000000, 32'h00000000, 1'b0, 1'b0},
    '{32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 1'b0},
    '{32'h80000000, 32'h80000000, 32'h80000000, 1'b0, 1'b0},
    '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 1'b0},
    '{32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b0},
    '{32'h00010000, 32'h00020000, 32'hFFFF0000, 1'b0, 1'b0},
    '{32'h00050000, 32'hFFF80000, 32'h00030000, 1'b0, 1'b0},
    '{32'hFFFE8000, 32'h00048000, 32'h00000001, 1'b0, 1'b0},
    '{32'h00090000, 32'h00010000, 32'hFFFFFFFF, 1'b0, 1'b0},
    '{32'h000A0000, 32'h00000000, 32'h00020000, 1'b1, 1'b0}
  };

  initial begin
    int sent = 0;
    int len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_waypoint(directed[i].x, directed[i].y, directed[i].z, directed[i].last,
                    directed[i].typed);

    // No pull toward the originals, full smoothing, the widest tolerance; a stray index is ignored.
    reconfigure(0, 65535, 32'hFFFFFFFF);
    write_reg(CfgUnused, 32'hDEADBEEF);
    cfg_we <= 1'b0;
    for (int i = 0; i < 4; i++) send_waypoint(rand_coord(), $urandom, rand_coord(), i == 3, 0);

    // Zero tolerance can never be met, so the sweep cap ends the run.
    reconfigure(65535, 0, 0);
    for (int i = 0; i < 3; i++) send_waypoint(rand_coord(), rand_coord(), rand_coord(), i == 2, 0);

    // A full store ends the path even though no point carries the final flag.
    reconfigure(pgs_pkg::DataWeightRst, pgs_pkg::SmoothWeightRst, 32'hFFFFFFFF);
    send_eager = 1'b1;
    for (int i = 0; i < NumPts; i++) send_waypoint($urandom, $urandom, $urandom, 1'b0, 0);

    while (sent < RandItems) begin
      reconfigure($urandom_range(16384, 65535), $urandom_range(0, 32768),
                  $urandom_range(66, 32'h0010_0000));
      send_eager = $urandom_range(0, 2) == 0;
      for (int p = 0; p < 6; p++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          send_waypoint(rand_coord(), rand_coord(), rand_coord(), i == len - 1, 0);
          sent++;
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    typed_pending <= 1'b0;
    @(posedge clk);
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Covered %0d paths (%0d stopped by the sweep cap), %0d output beats checked,",
             paths_done, capped_runs, beats_seen);
    $display("including single and two point paths, a full store and %0d random waypoints.",
             sent);
    if (mismatches == 0 && smoothed_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
